### rtl/adclp_pkg.sv
// Package for the ASCII digit command line parser.
// Holds the shared constants, types and digit helper functions; depends on nothing.
package adclp_pkg;

    localparam int LINE_CAPACITY_DEF = 50;
    localparam int COUNT_W           = 6;
    localparam int HEAD_DEPTH        = 5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

    localparam logic [1:0] ADDR_DUAL_PAIR = 2'd1;
    localparam logic [1:0] ADDR_SINGLE_A  = 2'd2;
    localparam logic [1:0] ADDR_SINGLE_B  = 2'd3;

    // Snapshot of the line as it stands before the current byte is applied.
    typedef struct packed {
        logic [COUNT_W-1:0]               line_count;
        logic [7:0]                       digit_sum;
        logic [7:0]                       last_char;
        logic [7:0]                       previous_char;
        logic [HEAD_DEPTH-1:0][7:0]       head_bytes;
    } line_view_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] target_address;
        logic [7:0] first_value;
        logic [7:0] second_value;
    } check_result_t;

    function automatic logic [7:0] dig(input logic [7:0] c);
        return c - DIGIT_BASE;
    endfunction

    // Ten times a value, mod 256, as two shifts and an add.
    function automatic logic [7:0] times_ten(input logic [7:0] v);
        return {v[4:0], 3'b000} + {v[6:0], 1'b0};
    endfunction

endpackage

### rtl/ascii_digit_command_line_parser_unit.sv
// Top level of the ASCII digit command line parser.
// Depends on adclp_pkg, adclp_line_state and adclp_line_check.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+----------------------------------------
//   receive   | in        | rx_valid / rx_stall    | rx_byte
//   result    | out       | result_valid / stall   | target_address, first_value, second_value
//
// Every received word is held in the input register and is applied to the line state
// when it moves on; the result for its newline word is then loaded into the result register.
// One word can be accepted in every cycle while rx_stall is low; the line state is updated
// as the word leaves the input register, alongside the result register.
// Reset clears the line state and both valid flags. While a result waits under
// result_stall, the input register keeps taking words until it is itself full.
module ascii_digit_command_line_parser_unit #(
    parameter int LINE_CAPACITY = adclp_pkg::LINE_CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] target_address,
    output logic [7:0] first_value,
    output logic [7:0] second_value
);
    import adclp_pkg::*;

    // Input register stage.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // Result register stage.
    logic          out_valid_reg;
    logic          out_valid_next;
    check_result_t out_data_reg;

    logic          advance;
    line_view_t    line_view;
    check_result_t check_result;
    logic          line_done;

    // The held word moves on whenever the result register is free or being emptied.
    assign advance   = !out_valid_reg || !result_stall;
    assign rx_stall  = in_valid_reg && !advance;
    assign line_done = in_valid_reg && (in_byte_reg == CHAR_LF);

    adclp_line_state #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(in_valid_reg && advance),
        .rx_byte   (in_byte_reg),
        .line_view (line_view)
    );

    adclp_line_check u_check (
        .line_view   (line_view),
        .check_result(check_result)
    );

    always_comb
    begin
        in_valid_next = rx_stall ? in_valid_reg : rx_valid;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            // Only a newline that passes every check produces a word.
            out_valid_next = line_done && check_result.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && line_done && check_result.ok)
        begin
            out_data_reg <= check_result;
        end
    end

    assign result_valid   = out_valid_reg;
    assign target_address = out_data_reg.target_address;
    assign first_value    = out_data_reg.first_value;
    assign second_value   = out_data_reg.second_value;

endmodule

### rtl/adclp_line_state.sv
// Line state registers: count, running digit sum, last two characters and head bytes.
// Depends on adclp_pkg.
module adclp_line_state #(
    parameter int LINE_CAPACITY = adclp_pkg::LINE_CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    output adclp_pkg::line_view_t line_view
);
    import adclp_pkg::*;

    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(LINE_CAPACITY);

    line_view_t view_reg;
    line_view_t view_next;
    logic [COUNT_W-1:0] base_count;
    logic [7:0]         base_sum;

    always_comb
    begin
        base_count = (view_reg.line_count >= CAP) ? '0 : view_reg.line_count;
        base_sum   = (view_reg.line_count >= CAP) ? '0 : view_reg.digit_sum;
        view_next  = view_reg;
        if (byte_valid)
        begin
            if (rx_byte == CHAR_LF)
            begin
                view_next = '0;
            end
            else if (rx_byte != CHAR_CR)
            begin
                // A line that reached capacity restarts at position zero;
                // head positions not rewritten keep their stale bytes.
                for (int i = 0; i < HEAD_DEPTH; i++)
                begin
                    if (base_count == COUNT_W'(i))
                    begin
                        view_next.head_bytes[i] = rx_byte;
                    end
                end
                view_next.line_count    = base_count + COUNT_W'(1);
                view_next.digit_sum     = base_sum + dig(rx_byte);
                view_next.previous_char = view_reg.last_char;
                view_next.last_char     = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg <= '0;
        end
        else
        begin
            view_reg <= view_next;
        end
    end

    assign line_view = view_reg;

endmodule

### rtl/adclp_line_check.sv
// Line checker: checksum compare, address decode and value assembly for one line.
// Depends on adclp_pkg.
module adclp_line_check (
    input  adclp_pkg::line_view_t    line_view,
    output adclp_pkg::check_result_t check_result
);
    import adclp_pkg::*;

    logic [HEAD_DEPTH-1:0][7:0] view_bytes;
    logic [7:0] body_sum;
    logic [7:0] check_value;
    logic [7:0] addr_digit;
    logic       long_enough;

    always_comb
    begin
        // The terminator reads as zero at the current line length.
        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            view_bytes[i] = (line_view.line_count == COUNT_W'(i)) ? 8'd0
                                                                  : line_view.head_bytes[i];
        end
        long_enough = (line_view.line_count >= COUNT_W'(2));
        body_sum    = line_view.digit_sum - dig(line_view.last_char)
                      - dig(line_view.previous_char);
        check_value = times_ten(dig(line_view.previous_char)) + dig(line_view.last_char);
        addr_digit  = dig(view_bytes[0]);

        check_result                = '0;
        check_result.target_address = addr_digit[1:0];
        if (addr_digit == {6'd0, ADDR_DUAL_PAIR})
        begin
            check_result.first_value  = times_ten(dig(view_bytes[1])) + dig(view_bytes[2]);
            check_result.second_value = times_ten(dig(view_bytes[3])) + dig(view_bytes[4]);
        end
        else
        begin
            check_result.first_value  = dig(view_bytes[1]);
            check_result.second_value = dig(view_bytes[2]);
        end
        check_result.ok = long_enough && (check_value == body_sum)
                          && ((addr_digit == {6'd0, ADDR_DUAL_PAIR})
                              || (addr_digit == {6'd0, ADDR_SINGLE_A})
                              || (addr_digit == {6'd0, ADDR_SINGLE_B}));
    end

endmodule

### rtl/adclp_port_checker.sv
// Port-level checker for the ASCII digit command line parser, with its bind.
// Depends on the top level's ports only.
module adclp_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_stall,
    input logic [7:0] rx_byte,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] target_address,
    input logic [7:0] first_value,
    input logic [7:0] second_value
);

    // A stalled result word keeps its valid flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            ($stable(target_address) && $stable(first_value) && $stable(second_value)))
        else $error("result payload changed while stalled");

    // The receive side only stalls when the result side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> (result_valid && result_stall))
        else $error("receive stalled without a waiting result");

    // A stalled receive word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_stall) |=> (rx_valid && $stable(rx_byte)))
        else $error("receive word changed while stalled");

    // Address zero is never reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (target_address != 2'd0))
        else $error("result with address zero");

endmodule

bind ascii_digit_command_line_parser_unit adclp_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .target_address(target_address),
    .first_value   (first_value),
    .second_value  (second_value)
);
